// ===== src/bht_pkg.sv =====
package bht_pkg;

	// Fixed field widths of the stream payloads
	localparam int RAW_W    = 8;
	localparam int QRY_W    = 3;
	localparam int CNT_W    = 16;
	localparam int MASK_W   = 8;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 48;

	// Default button count
	localparam int BUTTON_COUNT_DEF = 8;

	// Counter codes
	localparam logic [CNT_W-1:0] CNT_IDLE     = 16'h0000;
	localparam logic [CNT_W-1:0] CNT_FIRST    = 16'h0001;
	localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFE;
	localparam logic [CNT_W-1:0] CNT_RELEASED = 16'hFFFF;

	// Remainder unit: bits retired per cycle and remainder steps per button
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = CNT_W / DIV_BITS;
	localparam int DIV_IT_W  = $clog2(DIV_STEPS);

	// Configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 1'b1;

	localparam logic [CNT_W-1:0] HOLD_FRAMES_RST   = 16'd1;
	localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 16'd0;

	// Controller to datapath commands
	typedef struct packed {
		logic start;      // latch request, clear masks, rewind button index
		logic update;     // update counter of current button, seed remainder
		logic divide;     // one remainder step
		logic finish_btn; // record repeat bit, advance button
		logic publish;    // load output register
	} bht_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_div;
		logic last_btn;
		logic out_busy;
	} bht_sts_t;

endpackage

// ===== src/bht_ctrl.sv =====
module bht_ctrl
	import bht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  bht_sts_t sts,
	output bht_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_FINISH,
		ST_PUBLISH
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.start      = (state_q == ST_IDLE) && req_valid;
		cmd.update     = (state_q == ST_UPDATE);
		cmd.divide     = (state_q == ST_DIVIDE);
		cmd.finish_btn = (state_q == ST_FINISH);
		cmd.publish    = (state_q == ST_PUBLISH) && !sts.out_busy;
	end

	// Sequencer: per button one update, DIV_STEPS remainder steps, one finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (sts.last_div) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= sts.last_btn ? ST_PUBLISH : ST_UPDATE;
				end
				ST_PUBLISH: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/bht_datapath.sv =====
module bht_datapath
	import bht_pkg::*;
#(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bht_cmd_t             cmd,
	output bht_sts_t             sts,
	input  logic [RAW_W-1:0]     raw_buttons,
	input  logic [QRY_W-1:0]     query_button,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MASK_W-1:0]    pressed_mask,
	output logic [MASK_W-1:0]    released_mask,
	output logic [MASK_W-1:0]    held_mask,
	output logic [MASK_W-1:0]    repeat_mask,
	output logic [CNT_W-1:0]     held_time
);

	// Buttons past the sample width never leave idle, so only these are kept
	localparam int LANES = (BUTTON_COUNT < RAW_W) ? BUTTON_COUNT : RAW_W;
	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [CNT_W-1:0]    cnt_q [LANES];
	logic [LANES-1:0]    raw_q;
	logic [QRY_W-1:0]    query_q;
	logic [IDX_W-1:0]    btn_q;
	logic [DIV_IT_W-1:0] iter_q;
	logic [CNT_W-1:0]    cur_q;
	logic [CNT_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [LANES-1:0]    pm_q, rm_q, hm_q, pr_q;
	logic [CNT_W-1:0]    ht_q;
	logic [CNT_W-1:0]    hold_frames_q;
	logic [CNT_W-1:0]    repeat_period_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   pm_out_q, rm_out_q, hm_out_q, pr_out_q;
	logic [CNT_W-1:0]    ht_out_q;

	logic [CNT_W-1:0]    c_old, c_new;
	logic                down;
	logic [CNT_W:0]      target;
	logic [CNT_W-1:0]    rem_nxt;
	logic [CNT_W-1:0]    div_nxt;
	logic                rep_hit;

	// Next counter value of the current button
	always_comb begin
		c_old = cnt_q[btn_q];
		down  = !raw_q[btn_q];
		if (down) begin
			if (c_old < CNT_MAX)            c_new = c_old + CNT_FIRST;
			else if (c_old == CNT_RELEASED) c_new = CNT_FIRST;
			else                            c_new = c_old;
		end else begin
			if (c_old == CNT_IDLE || c_old == CNT_RELEASED) c_new = CNT_IDLE;
			else                                           c_new = CNT_RELEASED;
		end
	end

	assign target = {1'b0, hold_frames_q} + {{CNT_W{1'b0}}, 1'b1};

	// Restoring remainder, DIV_BITS dividend bits per cycle
	always_comb begin
		logic [CNT_W:0] trial;
		rem_nxt = rem_q;
		div_nxt = div_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial   = {rem_nxt, div_nxt[CNT_W-1]};
			div_nxt = {div_nxt[CNT_W-2:0], 1'b0};
			if (trial >= {1'b0, repeat_period_q})
				rem_nxt = CNT_W'(trial - {1'b0, repeat_period_q});
			else
				rem_nxt = trial[CNT_W-1:0];
		end
	end

	assign rep_hit = (cur_q != CNT_IDLE) && (cur_q != CNT_RELEASED) &&
		((repeat_period_q <= CNT_FIRST) || (rem_q == CNT_FIRST));

	assign sts.last_div = (iter_q == DIV_IT_W'(DIV_STEPS - 1));
	assign sts.last_btn = (btn_q == IDX_W'(LANES - 1));
	assign sts.out_busy = out_valid_q && !out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_frames_q   <= HOLD_FRAMES_RST;
			repeat_period_q <= REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLD_FRAMES:   hold_frames_q   <= cfg_data;
				REG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) cnt_q[i] <= CNT_IDLE;
		end else if (cmd.update) begin
			cnt_q[btn_q] <= c_new;
		end
	end

	// Sweep control: button index and remainder step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q  <= '0;
			iter_q <= '0;
		end else begin
			if (cmd.start)      btn_q  <= '0;
			if (cmd.finish_btn) btn_q  <= btn_q + IDX_W'(1);
			if (cmd.update)     iter_q <= '0;
			if (cmd.divide)     iter_q <= iter_q + DIV_IT_W'(1);
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			raw_q   <= raw_buttons[LANES-1:0];
			query_q <= query_button;
			pm_q    <= '0;
			rm_q    <= '0;
			hm_q    <= '0;
			pr_q    <= '0;
			ht_q    <= CNT_IDLE;
		end
		if (cmd.update) begin
			cur_q <= c_new;
			div_q <= c_new;
			rem_q <= CNT_IDLE;
			pm_q[btn_q] <= (c_new == CNT_FIRST);
			rm_q[btn_q] <= (c_new == CNT_RELEASED);
			hm_q[btn_q] <= ({1'b0, c_new} == target);
			if (QRY_W'(btn_q) == query_q)
				ht_q <= (c_new == CNT_RELEASED) ? CNT_IDLE : c_new;
		end
		if (cmd.divide) begin
			rem_q <= rem_nxt;
			div_q <= div_nxt;
		end
		if (cmd.finish_btn) begin
			pr_q[btn_q] <= rep_hit;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pm_out_q <= MASK_W'(pm_q);
			rm_out_q <= MASK_W'(rm_q);
			hm_out_q <= MASK_W'(hm_q);
			pr_out_q <= MASK_W'(pr_q);
			ht_out_q <= ht_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pressed_mask  = pm_out_q;
	assign released_mask = rm_out_q;
	assign held_mask     = hm_out_q;
	assign repeat_mask   = pr_out_q;
	assign held_time     = ht_out_q;

endmodule

// ===== src/button_hold_tracker_top.sv =====
// Button hold tracker. Each request on the slave stream is one frame sample of
// up to eight active-low buttons plus a query index; each yields exactly one
// result on the master stream with the just-pressed, just-released, held and
// repeat masks and the held time of the queried button. Buttons are visited
// one after another through a single remainder unit that retires four bits per
// cycle, and each request is swept over all buttons before the next is taken;
// the result sits in an output register, so a stalled master side does not
// hold up the next sample until its own result is ready. Registers hold_frames
// (index 0) and repeat_period (index 1) are written through the cfg channel,
// which is always ready, and must only be written while no request is in flight.
module button_hold_tracker_top
	import bht_pkg::*;
#(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // [7:0] raw_buttons, [10:8] query_button
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // [7:0] pressed_mask, [15:8] released_mask,
	                                        // [23:16] held_mask, [31:24] repeat_mask,
	                                        // [47:32] held_time
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	bht_cmd_t cmd;
	bht_sts_t sts;

	logic [MASK_W-1:0] pressed_mask, released_mask, held_mask, repeat_mask;
	logic [CNT_W-1:0]  held_time;

	assign cfg_ready = 1'b1;

	bht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bht_datapath #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.raw_buttons   (s_tdata[RAW_W-1:0]),
		.query_button  (s_tdata[RAW_W+QRY_W-1:RAW_W]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.pressed_mask  (pressed_mask),
		.released_mask (released_mask),
		.held_mask     (held_mask),
		.repeat_mask   (repeat_mask),
		.held_time     (held_time)
	);

	assign m_tdata = {held_time, repeat_mask, held_mask, released_mask, pressed_mask};

endmodule
